### rtl/core/ultrasonic_ranging_controller_top_macros.svh
// Assertion macros for the ultrasonic ranging controller.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef ULTRASONIC_RANGING_CONTROLLER_TOP_MACROS_SVH
`define ULTRASONIC_RANGING_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define URC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urc assertion failed");

// next-cycle implication
`define URC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urc assertion failed");

`endif

### rtl/core/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// Types and constants shared by the ultrasonic ranging controller.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int TIME_W  = 20;   // echo time and threshold registers
  localparam int DIST_W  = 28;
  localparam int TRIG_W  = 8;
  localparam int PROD_W  = DIST_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TIME_W;
  localparam int DEF_COUNT_WIDTH = 20;

  // distance in um = ticks * 343 / 2
  localparam logic [PROD_W-1:0] SOUND_NUM = PROD_W'(343);

  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam logic [TIME_W-1:0] GAP_RESET     = TIME_W'(1000);
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(100000);
  localparam logic [TRIG_W-1:0] TRIG_RESET    = TRIG_W'(10);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 3 + TIME_W + DIST_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_GAP       = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_TRIG_WIDTH = 2'd3
  } urc_reg_idx_t;

  typedef struct packed {
    logic              enable;
    logic [TIME_W-1:0] gap_period_us;
    logic [TIME_W-1:0] timeout_us;
    logic [TRIG_W-1:0] trigger_width_us;
  } urc_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_um;
    logic [TIME_W-1:0] echo_time_us;
    logic              new_reading;
    logic              waiting_echo;
    logic              trigger_level;
  } urc_result_t;

endpackage

### rtl/core/urc_cfg_regs.sv
// ----------------------------------------------------------------------------
// urc_cfg_regs
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module urc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [urc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output urc_pkg::urc_cfg_t                  cfg
);
  import urc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= 1'b0;
      cfg.gap_period_us    <= GAP_RESET;
      cfg.timeout_us       <= TIMEOUT_RESET;
      cfg.trigger_width_us <= TRIG_RESET;
    end else if (cfg_we) begin
      unique case (urc_reg_idx_t'(cfg_addr))
        REG_ENABLE:     cfg.enable           <= cfg_wdata[0];
        REG_GAP:        cfg.gap_period_us    <= cfg_wdata[TIME_W-1:0];
        REG_TIMEOUT:    cfg.timeout_us       <= cfg_wdata[TIME_W-1:0];
        REG_TRIG_WIDTH: cfg.trigger_width_us <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/urc_in_reg.sv
// ----------------------------------------------------------------------------
// urc_in_reg
// Input register for the echo sample stream.
// ----------------------------------------------------------------------------
module urc_in_reg (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic echo_in,
  input  logic advance,     // downstream takes the held item this cycle
  output logic in_valid,
  output logic echo_level
);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      echo_level <= echo_in;
    end
  end

endmodule

### rtl/core/urc_engine.sv
// ----------------------------------------------------------------------------
// urc_engine
// Ranging state and per-tick update: echo timing, trigger pulse, ping timing.
// ----------------------------------------------------------------------------
module urc_engine #(
  parameter int COUNT_WIDTH = urc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 echo_level,
  input  urc_pkg::urc_cfg_t    cfg,
  output urc_pkg::urc_result_t result
);
  import urc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   ping_pending, ping_pending_next;
  logic [TRIG_W-1:0]      trigger_count, trigger_count_next;
  logic [COUNT_WIDTH-1:0] since_ping, since_ping_next;
  logic [COUNT_WIDTH-1:0] since_gap_start, since_gap_start_next;
  logic [COUNT_WIDTH-1:0] echo_count, echo_count_next;
  logic                   echo_prev;
  logic [TIME_W-1:0]      last_echo_time, last_echo_time_next;
  logic [DIST_W-1:0]      last_distance, last_distance_next;

  logic [TIME_W-1:0]      dur;
  logic [PROD_W-1:0]      prod;
  logic                   trig;
  logic                   fresh;
  logic                   timed_out;
  logic                   gap_done;

  // duration clamped to the output field range
  assign dur  = (CMP_W'(echo_count) > CMP_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(echo_count);
  assign prod = PROD_W'(dur) * SOUND_NUM;

  always_comb begin
    echo_count_next      = echo_count;
    last_echo_time_next  = last_echo_time;
    last_distance_next   = last_distance;
    ping_pending_next    = ping_pending;
    since_gap_start_next = since_gap_start;
    trigger_count_next   = trigger_count;
    fresh                = 1'b0;

    if (echo_level && !echo_prev) begin
      echo_count_next = COUNT_WIDTH'(1);
    end else if (echo_level) begin
      echo_count_next = (echo_count == CNT_MAX) ? CNT_MAX : echo_count + 1'b1;
    end else if (echo_prev) begin
      last_echo_time_next  = dur;
      last_distance_next   = prod[PROD_W-1:1];
      ping_pending_next    = 1'b0;
      since_gap_start_next = '0;
      fresh                = 1'b1;
    end

    trig = (trigger_count != '0);
    if (trig) begin
      trigger_count_next = trigger_count - 1'b1;
    end else if (since_gap_start_next != CNT_MAX) begin
      since_gap_start_next = since_gap_start_next + 1'b1;
    end
    since_ping_next = (since_ping == CNT_MAX) ? CNT_MAX : since_ping + 1'b1;

    timed_out = CMP_W'(since_ping_next) >= CMP_W'(cfg.timeout_us);
    gap_done  = CMP_W'(since_gap_start_next) >= CMP_W'(cfg.gap_period_us);

    if ((cfg.enable && ping_pending_next && timed_out) ||
        (cfg.enable && !ping_pending_next && gap_done)) begin
      ping_pending_next    = 1'b1;
      trigger_count_next   = cfg.trigger_width_us;
      since_ping_next      = '0;
      since_gap_start_next = '0;
    end else if (!cfg.enable && ping_pending_next && timed_out) begin
      ping_pending_next = 1'b0;
    end

    result.trigger_level = trig;
    result.waiting_echo  = ping_pending_next;
    result.new_reading   = fresh;
    result.echo_time_us  = last_echo_time_next;
    result.distance_um   = last_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ping_pending    <= 1'b1;
      trigger_count   <= TRIG_RESET;
      since_ping      <= '0;
      since_gap_start <= '0;
      echo_count      <= '0;
      echo_prev       <= 1'b0;
      last_echo_time  <= '0;
      last_distance   <= '0;
    end else if (fire) begin
      ping_pending    <= ping_pending_next;
      trigger_count   <= trigger_count_next;
      since_ping      <= since_ping_next;
      since_gap_start <= since_gap_start_next;
      echo_count      <= echo_count_next;
      echo_prev       <= echo_level;
      last_echo_time  <= last_echo_time_next;
      last_distance   <= last_distance_next;
    end
  end

endmodule

### rtl/core/urc_out_reg.sv
// ----------------------------------------------------------------------------
// urc_out_reg
// Result register for the output stream.
// ----------------------------------------------------------------------------
module urc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  urc_pkg::urc_result_t result_in,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic                 stall,
  output urc_pkg::urc_result_t result_out
);
  assign stall = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### rtl/core/ultrasonic_ranging_controller_top.sv
// An input transfer is captured in the input register; when the tick fires, its result
// is loaded into the output register, and the result transfer follows on m_tready.
// Throughput: 1 tick per cycle unless stalled; the state update is one registered pass.
// A stalled output holds the input register; a new tick still enters while it is empty.
// Reset (rst, synchronous): registers to defaults, one ping pending, trigger
// pulse of the default width starts on the first tick.
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller_top
// Ultrasonic ranging controller: trigger, echo timing and distance per tick.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller_top #(
  parameter int COUNT_WIDTH = urc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [urc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] echo_level
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] trigger_level, [1] waiting_echo, [2] new_reading,
  // [22:3] echo_time_us, [50:23] distance_um
  output logic [urc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [urc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import urc_pkg::*;

  urc_cfg_t    cfg;
  urc_result_t step_result;
  urc_result_t out_result;
  logic        in_valid;
  logic        echo_level;
  logic        stall;
  logic        fire;

  assign fire = in_valid && !stall;

  urc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  urc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .echo_in    (s_tdata[0]),
    .advance    (!stall),
    .in_valid   (in_valid),
    .echo_level (echo_level)
  );

  urc_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .echo_level (echo_level),
    .cfg        (cfg),
    .result     (step_result)
  );

  urc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .result_in  (step_result),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .stall      (stall),
    .result_out (out_result)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                    out_result.distance_um,
                    out_result.echo_time_us,
                    out_result.new_reading,
                    out_result.waiting_echo,
                    out_result.trigger_level};

endmodule

### rtl/core/urc_checker.sv
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks for the ultrasonic ranging controller, bound to the top.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranging_controller_top_macros.svh"

module urc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [urc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import urc_pkg::*;

  logic [TIME_W-1:0] echo_time;
  logic [DIST_W-1:0] distance;
  logic [PROD_W-1:0] expect_prod;

  assign echo_time   = m_tdata[TIME_W+2:3];
  assign distance    = m_tdata[DIST_W+TIME_W+2:TIME_W+3];
  assign expect_prod = PROD_W'(echo_time) * SOUND_NUM;

  // held result stays put while the sink stalls
  `URC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // input side only backs up behind a waiting result
  `URC_ASSERT_NOW(a_ready_backpressure, clk, rst, !s_tready, m_tvalid)

  // distance always matches the reported echo time
  `URC_ASSERT_NOW(a_dist_consistent, clk, rst, m_tvalid, distance == expect_prod[PROD_W-1:1])

  // a completed reading covers at least one tick of echo
  `URC_ASSERT_NOW(a_reading_nonzero, clk, rst, m_tvalid && m_tdata[2], echo_time != '0)

endmodule

bind ultrasonic_ranging_controller_top urc_checker u_urc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
